### design/bmhq_pkg.sv
// Shared types and constants for the binary min-heap priority queue.
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int KEY_W        = 32;
  localparam int COUNT_OUT_W  = 11;
  localparam int ERR_W        = 2;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 80;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_CMP,
    ST_PLACE,
    ST_POP_RD,
    ST_POP_LD,
    ST_DN_RD,
    ST_DN_CMP,
    ST_TOP_RD,
    ST_TOP_LD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    err_t                   err;
    logic [COUNT_OUT_W-1:0] count;
    logic [KEY_W-1:0]       top;
    logic [KEY_W-1:0]       popped;
  } res_t;

endpackage

### design/binary_min_heap_queue.sv
// Top level of the binary min-heap priority queue with its output register.
`timescale 1ns / 1ps

// Priority queue of signed 32-bit keys held as a binary min-heap in one
// CAPACITY-entry memory with two registered read ports and one write port.
// Each input transaction is a push (tuser 0) or a pop (tuser 1) and gives
// exactly one result transaction. One item is in work at a time: a push
// moves its key up one level per read-compare-write round trip through the
// heap memory, and a pop moves the key taken from the last slot down one
// level per such round trip; the engine takes no new transaction until the
// result has been handed to the output register. A full push or empty pop
// is flagged in the error field and leaves the heap as it was. No clearing
// pass is needed after reset.
module binary_min_heap_queue #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bmhq_pkg::IN_TDATA_W-1:0]     in_tdata,   // [31:0] value
  input  logic [0:0]                          in_tuser,   // [0] kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] popped_value, [63:32] top_value, [74:64] entry_count,
  // [76:75] error, [79:77] zero
  output logic [bmhq_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int RW = $bits(bmhq_pkg::res_t);

  logic           res_valid, res_ready;
  bmhq_pkg::res_t res;
  logic           out_tvalid_r;
  logic [RW-1:0]  out_data_r;

  bmhq_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_kind  (in_tuser[0]),
    .req_value (in_tdata),
    .req_ready (in_tready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(bmhq_pkg::OUT_TDATA_W - RW){1'b0}}, out_data_r};

endmodule

### design/bmhq_engine.sv
// Heap store, compare logic and the sift sequencer.
`timescale 1ns / 1ps

module bmhq_engine #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       req_valid,
  input  logic                       req_kind,
  input  logic [bmhq_pkg::KEY_W-1:0] req_value,
  output logic                       req_ready,
  output logic                       res_valid,
  input  logic                       res_ready,
  output bmhq_pkg::res_t             res
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;
  localparam int KW = bmhq_pkg::KEY_W;
  localparam int OW = bmhq_pkg::COUNT_OUT_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [KW-1:0] mem [CAPACITY];

  bmhq_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [KW-1:0]    cur_r, cur_nxt;
  logic [KW-1:0]    popped_r, popped_nxt;
  logic [KW-1:0]    top_r, top_nxt;
  bmhq_pkg::err_t   err_r, err_nxt;
  logic [KW-1:0]    rd0_r, rd1_r;

  logic          we;
  logic [AW-1:0] waddr, ra0, ra1;
  logic [KW-1:0] wdata;

  logic [AW-1:0] parent;
  logic [XW-1:0] lidx, ridx, cnt_x;
  logic          l_ok, r_ok, take_l, take_r, up_swap;
  logic [KW-1:0] best_val;
  logic [CW-1:0] cnt_dec;
  logic [CW+OW-1:0] cnt_wide;

  assign parent   = (pos_r - AW'(1)) >> 1;
  assign lidx     = {1'b0, pos_r, 1'b1};
  assign ridx     = {1'b0, pos_r, 1'b0} + XW'(2);
  assign cnt_x    = XW'(cnt_r);
  assign l_ok     = lidx < cnt_x;
  assign r_ok     = ridx < cnt_x;
  assign take_l   = l_ok && ($signed(rd0_r) < $signed(cur_r));
  assign best_val = take_l ? rd0_r : cur_r;
  assign take_r   = r_ok && ($signed(rd1_r) < $signed(best_val));
  assign up_swap  = $signed(rd0_r) > $signed(cur_r);
  assign cnt_dec  = cnt_r - CW'(1);
  assign cnt_wide = {{OW{1'b0}}, cnt_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bmhq_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (req_kind == bmhq_pkg::KIND_POP) begin
            state_nxt = (cnt_r == '0) ? bmhq_pkg::ST_TOP_RD : bmhq_pkg::ST_POP_RD;
          end else if (cnt_r == CAP_C) begin
            state_nxt = bmhq_pkg::ST_TOP_RD;
          end else begin
            state_nxt = (cnt_r == '0) ? bmhq_pkg::ST_PLACE : bmhq_pkg::ST_PUSH_RD;
          end
        end
      end
      bmhq_pkg::ST_PUSH_RD:  state_nxt = bmhq_pkg::ST_PUSH_CMP;
      bmhq_pkg::ST_PUSH_CMP: begin
        if (up_swap) begin
          state_nxt = (parent == '0) ? bmhq_pkg::ST_PLACE : bmhq_pkg::ST_PUSH_RD;
        end else begin
          state_nxt = bmhq_pkg::ST_TOP_RD;
        end
      end
      bmhq_pkg::ST_PLACE:  state_nxt = bmhq_pkg::ST_TOP_RD;
      bmhq_pkg::ST_POP_RD: state_nxt = bmhq_pkg::ST_POP_LD;
      bmhq_pkg::ST_POP_LD: begin
        state_nxt = (cnt_dec == '0) ? bmhq_pkg::ST_TOP_RD : bmhq_pkg::ST_DN_RD;
      end
      bmhq_pkg::ST_DN_RD:  state_nxt = bmhq_pkg::ST_DN_CMP;
      bmhq_pkg::ST_DN_CMP: begin
        state_nxt = (take_l || take_r) ? bmhq_pkg::ST_DN_RD : bmhq_pkg::ST_TOP_RD;
      end
      bmhq_pkg::ST_TOP_RD: state_nxt = bmhq_pkg::ST_TOP_LD;
      bmhq_pkg::ST_TOP_LD: state_nxt = bmhq_pkg::ST_EMIT;
      bmhq_pkg::ST_EMIT: begin
        if (res_ready) begin
          state_nxt = bmhq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bmhq_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory port control; the moving key stays in cur_r and
  // is written once at its final slot (hole-based sift)
  always_comb begin
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    cur_nxt    = cur_r;
    popped_nxt = popped_r;
    top_nxt    = top_r;
    err_nxt    = err_r;
    we         = 1'b0;
    waddr      = pos_r;
    wdata      = cur_r;
    ra0        = '0;
    ra1        = '0;
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    case (state_r)
      bmhq_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          popped_nxt = '0;
          cur_nxt    = req_value;
          err_nxt    = bmhq_pkg::ERR_OK;
          if (req_kind == bmhq_pkg::KIND_POP) begin
            if (cnt_r == '0) begin
              err_nxt = bmhq_pkg::ERR_EMPTY;
            end
          end else if (cnt_r == CAP_C) begin
            err_nxt = bmhq_pkg::ERR_FULL;
          end else begin
            pos_nxt = cnt_r[AW-1:0];
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      bmhq_pkg::ST_PUSH_RD: ra0 = parent;
      bmhq_pkg::ST_PUSH_CMP: begin
        we = 1'b1;
        if (up_swap) begin
          wdata   = rd0_r;
          pos_nxt = parent;
        end
      end
      bmhq_pkg::ST_PLACE: we = 1'b1;
      bmhq_pkg::ST_POP_RD: begin
        ra0 = '0;
        ra1 = cnt_dec[AW-1:0];
      end
      bmhq_pkg::ST_POP_LD: begin
        popped_nxt = rd0_r;
        cur_nxt    = rd1_r;
        cnt_nxt    = cnt_dec;
        pos_nxt    = '0;
      end
      bmhq_pkg::ST_DN_RD: begin
        ra0 = lidx[AW-1:0];
        ra1 = ridx[AW-1:0];
      end
      bmhq_pkg::ST_DN_CMP: begin
        we = 1'b1;
        if (take_r) begin
          wdata   = rd1_r;
          pos_nxt = ridx[AW-1:0];
        end else if (take_l) begin
          wdata   = rd0_r;
          pos_nxt = lidx[AW-1:0];
        end
      end
      bmhq_pkg::ST_TOP_RD: ra0 = '0;
      bmhq_pkg::ST_TOP_LD: top_nxt = (cnt_r == '0) ? '0 : rd0_r;
      bmhq_pkg::ST_EMIT:   res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmhq_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    cur_r    <= cur_nxt;
    popped_r <= popped_nxt;
    top_r    <= top_nxt;
    err_r    <= err_nxt;
  end

  assign res.popped = popped_r;
  assign res.top    = top_r;
  assign res.count  = cnt_wide[OW-1:0];
  assign res.err    = err_r;

endmodule

### design/bmhq_checker.sv
// Port-level checks for the heap queue, bound to the top level.
`timescale 1ns / 1ps

module bmhq_props (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [bmhq_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accepted transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in work");

  // empty pop reports an empty heap and no key
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[76:75] == bmhq_pkg::ERR_EMPTY
      |-> out_tdata[74:64] == '0 && out_tdata[31:0] == '0 && out_tdata[63:32] == '0)
    else $error("empty pop result not clean");

  // an empty heap shows top zero, the error code is always defined and the padding is zero
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[74:64] != '0 || out_tdata[63:32] == '0)
      && out_tdata[76:75] != 2'd3 && out_tdata[79:77] == '0)
    else $error("bad top or error field");

endmodule

bind binary_min_heap_queue bmhq_props u_bmhq_props (.*);

### tb/bmhq_checker.sv
// Checker for the min-heap queue: predicts each result and compares it on the output channel.
`timescale 1ns / 1ps

module bmhq_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [bmhq_pkg::IN_TDATA_W-1:0]     in_tdata,   // [31:0] value
  input  logic [0:0]                          in_tuser,   // [0] kind
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] popped_value, [63:32] top_value, [74:64] entry_count,
  // [76:75] error, [79:77] zero
  input  logic [bmhq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output int                                  fail_count,
  output int                                  outstanding
);
  import bmhq_pkg::*;

  localparam int RES_W = $bits(res_t);

  logic signed [KEY_W-1:0] heap_keys [CAPACITY_DEF];
  int unsigned             held;
  res_t                    pending_results [$];

  // Apply one push or pop to the shadow heap and return the result it gives.
  function automatic res_t apply_op(logic kind, logic signed [KEY_W-1:0] key);
    res_t                    r;
    int unsigned             pos;
    int unsigned             up;
    int unsigned             best;
    int unsigned             lft;
    int unsigned             rgt;
    logic signed [KEY_W-1:0] t;
    r = '0;
    r.err = ERR_OK;
    if (kind == KIND_PUSH) begin
      if (held >= CAPACITY_DEF) begin
        r.err = ERR_FULL;
      end else begin
        pos = held;
        heap_keys[pos] = key;
        held++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_keys[up] <= heap_keys[pos]) break;
          t = heap_keys[up];
          heap_keys[up] = heap_keys[pos];
          heap_keys[pos] = t;
          pos = up;
        end
      end
    end else if (held == 0) begin
      r.err = ERR_EMPTY;
    end else begin
      r.popped = heap_keys[0];
      held--;
      heap_keys[0] = heap_keys[held];
      pos = 0;
      while (1) begin
        best = pos;
        lft  = 2 * pos + 1;
        rgt  = 2 * pos + 2;
        // left child wins a tie
        if (lft < held && heap_keys[lft] < heap_keys[best]) best = lft;
        if (rgt < held && heap_keys[rgt] < heap_keys[best]) best = rgt;
        if (best == pos) break;
        t = heap_keys[best];
        heap_keys[best] = heap_keys[pos];
        heap_keys[pos] = t;
        pos = best;
      end
    end
    r.top   = (held != 0) ? heap_keys[0] : '0;
    r.count = COUNT_OUT_W'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    int   errs;
    errs = 0;
    if (!rst_n) begin
      held = 0;
      pending_results.delete();
      fail_count <= 0;
    end else begin
      // a result leaving this edge belongs to an item accepted earlier
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[RES_W-1:0]);
        if (pending_results.size() == 0) begin
          errs++;
          $display("%0t: unexpected result transaction, expected none, got %h",
                   $time, out_tdata);
        end else begin
          want = pending_results.pop_front();
          if (got.popped !== want.popped) begin
            errs++;
            $display("%0t: popped_value expected %0d got %0d", $time,
                     $signed(want.popped), $signed(got.popped));
          end
          if (got.top !== want.top) begin
            errs++;
            $display("%0t: top_value expected %0d got %0d", $time,
                     $signed(want.top), $signed(got.top));
          end
          if (got.count !== want.count) begin
            errs++;
            $display("%0t: entry_count expected %0d got %0d", $time, want.count, got.count);
          end
          if (got.err !== want.err) begin
            errs++;
            $display("%0t: error expected %0d got %0d", $time, want.err, got.err);
          end
          if (out_tdata[OUT_TDATA_W-1:RES_W] !== '0) begin
            errs++;
            $display("%0t: tdata padding expected 0 got %b", $time,
                     out_tdata[OUT_TDATA_W-1:RES_W]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        pending_results.push_back(apply_op(in_tuser[0], in_tdata));
      end
      fail_count <= fail_count + errs;
    end
    outstanding <= pending_results.size();
  end

endmodule

### tb/tb_top.sv
// Testbench top for the min-heap queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import bmhq_pkg::*;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [31:0] value
  logic [0:0]             in_tuser;   // [0] kind
  logic                   out_tvalid;
  logic                   out_tready;
  // [31:0] popped_value, [63:32] top_value, [74:64] entry_count,
  // [76:75] error, [79:77] zero
  logic [OUT_TDATA_W-1:0] out_tdata;

  int fail_count;
  int outstanding;
  int fill_level;
  bit quiet;

  binary_min_heap_queue i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  bmhq_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls about 11% of cycles unless in a quiet stretch
  always @(negedge clk) begin
    out_tready = quiet || ($urandom_range(0, 99) >= 11);
  end

  initial begin
    #10_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // Mix of extremes, small keys that tie often, and full-range keys.
  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3:    return KEY_W'($signed($urandom_range(0, 15)) - 8);
      4:       return {KEY_W{$urandom_range(0, 1) == 1}};
      default: return $urandom;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic submit_op(input logic kind, input logic [KEY_W-1:0] key);
    while (!quiet && $urandom_range(0, 99) < 11) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = key;
    do @(posedge clk); while (!in_tready);
    if (kind == KIND_PUSH && fill_level < CAPACITY_DEF) fill_level++;
    if (kind == KIND_POP && fill_level > 0) fill_level--;
    @(negedge clk);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = KIND_PUSH;
    in_tdata   = '0;
    quiet      = 1'b0;
    fill_level = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty pop, single entry, extremes, ties, bit patterns
    submit_op(KIND_POP, 32'hffff_ffff);
    submit_op(KIND_PUSH, 32'h0000_0000);
    submit_op(KIND_POP, 32'h0000_0000);
    submit_op(KIND_POP, 32'h0000_0000);
    submit_op(KIND_PUSH, 32'h7fff_ffff);
    submit_op(KIND_PUSH, 32'h8000_0000);
    submit_op(KIND_PUSH, 32'hffff_ffff);
    submit_op(KIND_PUSH, 32'h0000_0000);
    submit_op(KIND_PUSH, 32'h0000_0001);
    submit_op(KIND_PUSH, 32'h8000_0000);
    submit_op(KIND_PUSH, 32'h0000_0005);
    submit_op(KIND_PUSH, 32'h0000_0005);
    submit_op(KIND_PUSH, 32'haaaa_aaaa);
    submit_op(KIND_PUSH, 32'h5555_5555);
    repeat (11) submit_op(KIND_POP, 32'hffff_ffff);

    // mostly pushes until full, with a stretch of no idling partway
    while (fill_level < CAPACITY_DEF) begin
      quiet = (fill_level >= 300 && fill_level < 500);
      submit_op(($urandom_range(0, 99) < 98) ? KIND_PUSH : KIND_POP, rand_key());
    end
    quiet = 1'b0;
    repeat (6) submit_op(KIND_PUSH, rand_key());
    repeat (4) submit_op(1'($urandom_range(0, 1)), rand_key());

    // mostly pops from a deep heap down to about half full
    while (fill_level > 500) begin
      submit_op(($urandom_range(0, 99) < 95) ? KIND_POP : KIND_PUSH, rand_key());
    end

    // balanced mix
    repeat (150) submit_op(1'($urandom_range(0, 1)), rand_key());
    in_tvalid = 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
